@@ design/apts_pkg.sv @@
`timescale 1ns / 1ps

package apts_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TASKS_DEF  = 16;
  localparam int IDENT_BITS_DEF = 8;

  // Fixed payload widths
  localparam int ACTION_W = 2;
  localparam int IDENT_W  = 8;
  localparam int PRIO_W   = 6;
  localparam int STATUS_W = 3;

  typedef logic signed [PRIO_W-1:0] prio_t;

  localparam prio_t PRIO_MIN = -6'sd20;
  localparam prio_t PRIO_MAX = 6'sd20;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SETPRIO = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SCHED   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDENT_W-1:0]  task_ident;
    prio_t               priority_req;
  } req_t;

  typedef struct packed {
    logic [IDENT_W-1:0]  chosen_ident;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Shared compare / aging unit
  typedef struct packed {
    prio_t cand_prio;
    prio_t pick_prio;
  } unit_req_t;

  typedef struct packed {
    logic  take;
    prio_t aged;
  } unit_rsp_t;

  function automatic prio_t clamp_prio(input prio_t raw);
    prio_t v;
    v = raw;
    if (v < PRIO_MIN) v = PRIO_MIN;
    if (v > PRIO_MAX) v = PRIO_MAX;
    return v;
  endfunction

endpackage

@@ design/apts_if.sv @@
`timescale 1ns / 1ps

// Request channel
interface apts_req_if import apts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [IDENT_W-1:0]  task_ident;
  prio_t               priority_req;

  modport source (output valid, action, task_ident, priority_req, input ready);
  modport sink   (input valid, action, task_ident, priority_req, output ready);
endinterface

// Response channel
interface apts_rsp_if import apts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDENT_W-1:0]  chosen_ident;
  logic [STATUS_W-1:0] status;

  modport source (output valid, chosen_ident, status, input ready);
  modport sink   (input valid, chosen_ident, status, output ready);
endinterface

@@ design/apts_unit.sv @@
`timescale 1ns / 1ps

module apts_unit import apts_pkg::*; (
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  prio_t loser;

  // Strictly lower candidate replaces the pick; the other one ages toward the floor
  always_comb begin
    rsp_o.take = req_i.cand_prio < req_i.pick_prio;
    loser      = rsp_o.take ? req_i.pick_prio : req_i.cand_prio;
    rsp_o.aged = (loser > PRIO_MIN) ? prio_t'(loser - prio_t'(1)) : loser;
  end

endmodule

@@ design/apts_seq.sv @@
`timescale 1ns / 1ps

module apts_seq import apts_pkg::*; #(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int IDENT_BITS = IDENT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  typedef struct packed {
    logic [IDENT_BITS-1:0] ident;
    prio_t                 stat;
    prio_t                 dyn;
  } entry_t;

  // Control state
  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic             dv_q, dv_d;
  logic             found_q, found_d;

  // Payload state
  logic [ACTION_W-1:0]   act_q, act_d;
  logic [IDENT_BITS-1:0] id_q, id_d;
  prio_t                 prio_q, prio_d;
  logic [IDX_W-1:0]      di_q, di_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  entry_t                pick_q, pick_d;
  logic [IDX_W-1:0]      pick_idx_q, pick_idx_d;
  res_t                  res_q, res_d;

  // Task table
  entry_t           mem_q [MAX_TASKS];
  entry_t           rdata_q;
  logic             re, we;
  logic [IDX_W-1:0] raddr, waddr;
  entry_t           wdata;

  unit_req_t   unit_req;
  unit_rsp_t   unit_rsp;
  logic [15:0] pick_ident_w;

  apts_unit u_unit (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  assign pick_ident_w = 16'(pick_q.ident);
  assign unit_req.cand_prio = rdata_q.dyn;
  assign unit_req.pick_prio = pick_q.dyn;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o       = res_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_d       = rd_q;
    dv_d       = 1'b0;
    found_d    = found_q;
    act_d      = act_q;
    id_d       = id_q;
    prio_d     = prio_q;
    di_d       = di_q;
    slot_d     = slot_q;
    pick_d     = pick_q;
    pick_idx_d = pick_idx_q;
    res_d      = res_q;
    re         = 1'b0;
    raddr      = rd_q[IDX_W-1:0];
    we         = 1'b0;
    waddr      = di_q;
    wdata      = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d              = req_i.action;
          id_d               = IDENT_BITS'(req_i.task_ident);
          prio_d             = clamp_prio(req_i.priority_req);
          rd_d               = '0;
          found_d            = 1'b0;
          res_d.chosen_ident = '0;
          res_d.status       = ST_OK;
          if (req_i.action == ACT_SCHED && cnt_q == '0) begin
            res_d.status = ST_EMPTY;
            state_d      = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // One table read per cycle; data is handled the cycle after its read
      S_SCAN: begin
        if (rd_q < cnt_q) begin
          re   = 1'b1;
          rd_d = rd_q + CNT_W'(1);
          dv_d = 1'b1;
          di_d = rd_q[IDX_W-1:0];
        end
        if (dv_q) begin
          if (act_q != ACT_SCHED) begin
            // id lookup
            if (rdata_q.ident == id_q) begin
              found_d = 1'b1;
              slot_d  = di_q;
              dv_d    = 1'b0;
              state_d = S_ACT;
            end
          end else if (di_q == '0) begin
            pick_d     = rdata_q;
            pick_idx_d = di_q;
          end else begin
            // write back the aged loser
            we = 1'b1;
            if (unit_rsp.take) begin
              waddr      = pick_idx_q;
              wdata      = pick_q;
              wdata.dyn  = unit_rsp.aged;
              pick_d     = rdata_q;
              pick_idx_d = di_q;
            end else begin
              waddr     = di_q;
              wdata     = rdata_q;
              wdata.dyn = unit_rsp.aged;
            end
          end
        end else if (rd_q >= cnt_q) begin
          state_d = S_ACT;
        end
      end

      S_ACT: begin
        state_d = S_FIN;
        case (act_q)
          ACT_INSERT: begin
            if (found_q) begin
              res_d.status = ST_PRESENT;
            end else if (cnt_q == CNT_W'(MAX_TASKS)) begin
              res_d.status = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = cnt_q[IDX_W-1:0];
              wdata.ident = id_q;
              wdata.stat = prio_q;
              wdata.dyn  = prio_q;
              cnt_d      = cnt_q + CNT_W'(1);
            end
          end
          ACT_REMOVE: begin
            if (!found_q) begin
              res_d.status = ST_ABSENT;
            end else begin
              rd_d    = CNT_W'(slot_q) + CNT_W'(1);
              state_d = S_SHIFT;
            end
          end
          ACT_SETPRIO: begin
            if (!found_q) begin
              res_d.status = ST_ABSENT;
            end else begin
              we          = 1'b1;
              waddr       = slot_q;
              wdata.ident = id_q;
              wdata.stat  = prio_q;
              wdata.dyn   = prio_q;
            end
          end
          ACT_SCHED: begin
            we                 = 1'b1;
            waddr              = pick_idx_q;
            wdata              = pick_q;
            wdata.dyn          = pick_q.stat;
            res_d.chosen_ident = pick_ident_w[IDENT_W-1:0];
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      // Close the gap: move each later entry down by one
      S_SHIFT: begin
        if (rd_q < cnt_q) begin
          re   = 1'b1;
          rd_d = rd_q + CNT_W'(1);
          dv_d = 1'b1;
          di_d = rd_q[IDX_W-1:0];
        end
        if (dv_q) begin
          we    = 1'b1;
          waddr = di_q - IDX_W'(1);
          wdata = rdata_q;
        end else if (rd_q >= cnt_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rd_q    <= '0;
      dv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      dv_q    <= dv_d;
      found_q <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    id_q       <= id_d;
    prio_q     <= prio_d;
    di_q       <= di_d;
    slot_q     <= slot_d;
    pick_q     <= pick_d;
    pick_idx_q <= pick_idx_d;
    res_q      <= res_d;
  end

  // Table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TASKS))
    else $error("ready count above table size");

  a_chosen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && act_q != ACT_SCHED |-> res_o.chosen_ident == '0)
    else $error("nonzero chosen id on a non-schedule action");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_EMPTY |-> cnt_q == '0)
    else $error("empty status with entries in the table");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_FULL |-> cnt_q == CNT_W'(MAX_TASKS))
    else $error("full status with room in the table");

  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> $past(state_q) == S_ACT || $past(state_q) == S_SHIFT)
    else $error("ready count changed outside insert or remove");
`endif

endmodule

@@ design/aging_priority_task_scheduler.sv @@
`timescale 1ns / 1ps

// Priority task scheduler with aging.
// Request channel req_i carries action, task_ident and priority_req; the response
// channel rsp_o carries chosen_ident and status, exactly one item per request.
// Actions: insert appends a task at the tail, remove deletes it and closes the
// gap, set-priority rewrites both priorities, schedule picks the lowest dynamic
// priority (earliest wins ties) and ages every loser by one toward -20.
// Priorities are clamped to -20..20.
// Timing: one request is worked on at a time. A schedule reads every entry of
// the table and an insert reads until it finds the id or reaches the tail,
// because the table memory is read one entry per cycle by the sequencer, and a
// remove moves each later entry through it. The next request is taken only once
// the sequencer has handed its result on.
// The response sits in an output register, so the next request is taken while
// a response still waits; if the receiver stalls longer, the block holds the
// following result and does not accept further requests until it drains.
// Reset empties the table (ready count to zero); no clearing pass is needed.
module aging_priority_task_scheduler import apts_pkg::*; #(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int IDENT_BITS = IDENT_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  apts_req_if.sink   req_i,
  apts_rsp_if.source rsp_o
);

  req_t req;
  res_t res;
  logic res_valid, res_ready;

  logic out_valid_q;
  res_t out_res_q;

  assign req.action       = req_i.action;
  assign req.task_ident   = req_i.task_ident;
  assign req.priority_req = req_i.priority_req;

  apts_seq #(
    .MAX_TASKS  (MAX_TASKS),
    .IDENT_BITS (IDENT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_res_q <= res;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.chosen_ident = out_res_q.chosen_ident;
  assign rsp_o.status       = out_res_q.status;

endmodule
